// ===== hdl/bce_pkg.sv =====
`default_nettype none

package bce_pkg;

    localparam int PIXEL_W = 8;
    localparam int COL_W = 10;
    localparam int ROW_W = 12;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 13;

    localparam int MIN_DIM = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int RESET_WIDTH = 20;
    localparam int RESET_HEIGHT = 20;

    localparam logic [PIXEL_W-1:0] FG_VALUE = 8'd255;
    localparam logic [PIXEL_W-1:0] BG_VALUE = 8'd0;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic             fg;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             two;
        logic             eof;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic {
        PH_MAIN,
        PH_BORDER
    } phase_t;

endpackage

`default_nettype wire

// ===== hdl/bce_ram.sv =====
`default_nettype none

module bce_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bce_fifo.sv =====
`default_nettype none

module bce_fifo
    import bce_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire job_t    push_job,
    input  wire logic    pop,
    output job_t         head,
    output queue_status_t status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    job_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   wptr_next;
    logic [PW-1:0]   rptr_reg;
    logic [PW-1:0]   rptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign status.full = (count_reg == CNTW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop = pop && !status.empty;
    assign head = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bce_front.sv =====
`default_nettype none

module bce_front
    import bce_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] width_last,
    input  wire logic [ROW_W-1:0]             height_last,
    input  wire logic                         restart,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [PIXEL_W-1:0]           pixel_in,
    input  wire queue_status_t                q_status,
    output logic                              q_push,
    output job_t                              q_job
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             rd_fresh_reg;
    logic [1:0]       win_mid_reg;
    logic [1:0]       win_right_reg;
    logic             left_reg;
    logic [1:0]       rd_data;
    logic [1:0]       right_bits;
    logic [CW-1:0]    rd_addr;
    logic             accept;
    logic             cur;
    logic             on_border;

    // Each store entry holds {two rows above, one row above} for its column.
    // The entry two columns ahead is fetched at every transfer, so the right
    // neighbor of the next pixel is ready when that pixel arrives.
    bce_ram #(
        .WIDTH(2),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .clk  (clk),
        .we   (accept),
        .waddr(col_reg),
        .wdata({win_mid_reg[0], cur}),
        .re   (accept),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign in_ready = !q_status.full;
    assign accept = in_valid && in_ready;
    assign cur = |pixel_in;
    assign right_bits = rd_fresh_reg ? rd_data : win_right_reg;

    always_comb
    begin
        if (col_reg == width_last)
        begin
            rd_addr = CW'(1);
        end
        else if (col_reg + CW'(1) == width_last)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = col_reg + CW'(2);
        end
    end

    always_comb
    begin
        on_border = (col_reg == '0) || (col_reg == width_last) || (row_reg == ROW_W'(1));
        q_push = accept && (row_reg != '0);
        q_job.fg = !on_border && win_mid_reg[0] && win_mid_reg[1] && cur && left_reg
                   && right_bits[0];
        q_job.column = COL_W'(col_reg);
        q_job.row = row_reg - ROW_W'(1);
        q_job.two = (row_reg == height_last);
        q_job.eof = (col_reg == width_last);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == width_last)
            begin
                col_next = '0;
                row_next = (row_reg == height_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            rd_fresh_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            rd_fresh_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        win_right_reg <= right_bits;
        if (accept)
        begin
            win_mid_reg <= right_bits;
            left_reg <= win_mid_reg[0];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bce_back.sv =====
`default_nettype none

module bce_back
    import bce_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire queue_status_t      q_status,
    input  wire job_t               q_head,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [PIXEL_W-1:0]      pixel_out,
    output logic [COL_W-1:0]        out_column,
    output logic [ROW_W-1:0]        out_row,
    output logic                    last_in_run,
    output logic                    end_of_frame
);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               load;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIXEL_W-1:0] pixel_reg;
    logic [PIXEL_W-1:0] pixel_next;
    logic [COL_W-1:0]   column_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic               last_reg;
    logic               last_next;
    logic               eof_reg;
    logic               eof_next;

    assign load = !q_status.empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_MAIN:
            begin
                if (load && q_head.two)
                begin
                    phase_next = PH_BORDER;
                end
            end
            PH_BORDER:
            begin
                if (load)
                begin
                    phase_next = PH_MAIN;
                end
            end
            default:
            begin
                phase_next = PH_MAIN;
            end
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        pixel_next = BG_VALUE;
        row_next = q_head.row;
        last_next = 1'b1;
        eof_next = 1'b0;
        case (phase_reg)
            PH_MAIN:
            begin
                q_pop = load && !q_head.two;
                pixel_next = q_head.fg ? FG_VALUE : BG_VALUE;
                last_next = !q_head.two;
            end
            PH_BORDER:
            begin
                q_pop = load;
                row_next = q_head.row + ROW_W'(1);
                eof_next = q_head.eof;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= pixel_next;
            column_reg <= q_head.column;
            row_reg <= row_next;
            last_reg <= last_next;
            eof_reg <= eof_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_reg;
    assign out_column = column_reg;
    assign out_row = row_reg;
    assign last_in_run = last_reg;
    assign end_of_frame = eof_reg;

endmodule

`default_nettype wire

// ===== hdl/binary_cross_erosion.sv =====
`default_nettype none

// Streaming binary erosion with a cross-shaped 3x3 element. Pixels enter in
// raster order, one per transfer, and any nonzero value counts as foreground.
// The result for row r-1 leaves while row r enters, so each input from the
// second row on gives one result; inputs of the last row give a second,
// all-zero border result for their own position, and inputs of the first row
// give none. The block takes one pixel per clock cycle while its queue is not
// full; on the last row each pixel gives two results, sent one per cycle by
// the output register after the queue while out_ready is high. Writing
// image_width or image_height restarts the frame at row 0, column 0; the
// line store keeps its contents and needs no clearing pass.
module binary_cross_erosion
    import bce_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [PIXEL_W-1:0]     pixel_in,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [PIXEL_W-1:0]          pixel_out,
    output logic [COL_W-1:0]            out_column,
    output logic [ROW_W-1:0]            out_row,
    output logic                        last_in_run,
    output logic                        end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [HEIGHT_REG_W-1:0] MAX_W_CMP = HEIGHT_REG_W'(MAX_WIDTH);

    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;
    logic                    cfg_accept;
    logic                    restart;
    logic [CW-1:0]           width_last;
    logic [ROW_W-1:0]        height_last;
    logic [HEIGHT_REG_W-1:0] width_cmp;
    queue_status_t           q_status;
    logic                    q_push;
    logic                    q_pop;
    job_t                    q_job;
    job_t                    q_head;

    assign cfg_ready = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign restart = cfg_accept && (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= WIDTH_REG_W'(RESET_WIDTH);
            image_height_reg <= HEIGHT_REG_W'(RESET_HEIGHT);
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default:          image_width_reg <= image_width_reg;
            endcase
        end
    end

    // Register values outside the supported range are clamped.
    assign width_cmp = HEIGHT_REG_W'(image_width_reg);

    always_comb
    begin
        if (width_cmp < HEIGHT_REG_W'(MIN_DIM))
        begin
            width_last = CW'(MIN_DIM - 1);
        end
        else if (width_cmp > MAX_W_CMP)
        begin
            width_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            width_last = CW'(width_cmp - HEIGHT_REG_W'(1));
        end

        if (image_height_reg < HEIGHT_REG_W'(MIN_DIM))
        begin
            height_last = ROW_W'(MIN_DIM - 1);
        end
        else if (image_height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
        begin
            height_last = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            height_last = ROW_W'(image_height_reg - HEIGHT_REG_W'(1));
        end
    end

    bce_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_last (width_last),
        .height_last(height_last),
        .restart    (restart),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_in   (pixel_in),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_job      (q_job)
    );

    bce_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_job(q_job),
        .pop     (q_pop),
        .head    (q_head),
        .status  (q_status)
    );

    bce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .out_column  (out_column),
        .out_row     (out_row),
        .last_in_run (last_in_run),
        .end_of_frame(end_of_frame)
    );

endmodule

`default_nettype wire

// ===== hdl/bce_checker.sv =====
`default_nettype none

module bce_checker
    import bce_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [PIXEL_W-1:0]     pixel_out,
    input wire logic [COL_W-1:0]       out_column,
    input wire logic [ROW_W-1:0]       out_row,
    input wire logic                   last_in_run,
    input wire logic                   end_of_frame
);

    // The eroded image carries only the two binary levels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_out == FG_VALUE || pixel_out == BG_VALUE))
        else $error("result pixel is neither background nor foreground");

    // The final pixel of a frame lies on the border and closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> (last_in_run && pixel_out == BG_VALUE))
        else $error("end of frame on a foreground pixel or inside a run");

    // The left column and the top row are always background.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_column == '0 || out_row == '0)) |-> (pixel_out == BG_VALUE))
        else $error("foreground on the frame border");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pixel_out)
                                      && $stable(out_column) && $stable(out_row)))
        else $error("stalled result changed");

endmodule

bind binary_cross_erosion bce_checker u_bce_checker (.*);

`default_nettype wire
